### rtl/core/ffba_pkg.sv
// ============================================================================
// ffba_pkg: shared types and constants of the first-fit block allocator
// Heap geometry, field widths, command and status bundles between the
// controller and the datapath, and the codes that travel in them.
// ============================================================================
`default_nettype none

package ffba_pkg;

    // Heap geometry: one tag word per 8 bytes
    localparam int HEAP_BYTES = 1024;
    localparam int HEAP_WORDS = HEAP_BYTES / 8;
    localparam int WORD_AW    = $clog2(HEAP_WORDS);
    localparam int FLAG_W     = 3;
    localparam int TAG_W      = $clog2(HEAP_BYTES) + 1;
    localparam int SIZE_W     = TAG_W - FLAG_W;

    // Stream field widths
    localparam int REQ_W      = 11;
    localparam int OFS_W      = 10;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;

    // Internal arithmetic widths, in tag words
    localparam int TAG_WORDS  = 2;
    localparam int NEED_W     = REQ_W - FLAG_W + 2;
    localparam int REL_W      = OFS_W - FLAG_W;
    localparam int ADDR_W     = (WORD_AW + 2 > REL_W) ? WORD_AW + 2 : REL_W;
    localparam int CMP_W      = ((NEED_W > SIZE_W) ? NEED_W : SIZE_W) + 1;

    // Tag flag patterns
    localparam logic [FLAG_W-1:0] TAKEN_FLAGS = 3'b001;
    localparam logic [FLAG_W-1:0] CLEAR_FLAGS = 3'b000;

    // Operation codes
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Read address sources
    typedef logic [1:0] rd_src_t;
    localparam rd_src_t RD_ZERO = 2'd0;
    localparam rd_src_t RD_NEXT = 2'd1;
    localparam rd_src_t RD_REL  = 2'd2;

    // Write address and value sources
    typedef logic [2:0] wr_src_t;
    localparam wr_src_t WR_HDR  = 3'd0;
    localparam wr_src_t WR_FTR  = 3'd1;
    localparam wr_src_t WR_RHDR = 3'd2;
    localparam wr_src_t WR_RFTR = 3'd3;
    localparam wr_src_t WR_REL  = 3'd4;

    // Result kinds
    typedef logic [1:0] res_kind_t;
    localparam res_kind_t RES_FAIL  = 2'd0;
    localparam res_kind_t RES_ALLOC = 2'd1;
    localparam res_kind_t RES_REL   = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic      capture;
        logic      rd_en;
        rd_src_t   rd_src;
        logic      wr_en;
        wr_src_t   wr_src;
        logic      latch_size;
        logic      load_out;
        res_kind_t res_kind;
    } ffba_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic op_release;
        logic rel_ok;
        logic fit;
        logic chain_end;
        logic split;
    } ffba_sts_t;

endpackage

`default_nettype wire

### rtl/core/first_fit_block_allocator_top.sv
// ============================================================================
// first_fit_block_allocator_top: first-fit heap allocator with boundary tags
// Allocates and releases payload blocks of a fixed heap, one word at a time.
// ============================================================================
// Each input word is an allocate (s_tuser 0) or a release (s_tuser 1) and
// gives exactly one result word. An allocate walks the block headers from
// the start of the heap, one header per cycle out of the tag memory read
// port. A granted allocate then writes the header and footer of the taken
// block, and a granted split also writes the header and footer of the
// remainder; a failed allocate goes to its result when the walk ends.
// Blocks are at least 16 bytes, so at most HEAP_BYTES/16 headers are visited.
// A release reads its header and writes it back with the flags clear; a
// rejected one goes from decode straight to its result. The input is ready
// again in the cycle after the result is loaded. The result sits in an
// output register, so a new word is taken while the previous result still
// waits on m_tready; the next result then waits until that one is taken.
// After reset the heap is one free block at once; there is no clearing pass.
// Releases clear the taken flag of the header only and never merge neighbors.
`default_nettype none

module first_fit_block_allocator_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [ffba_pkg::S_TDATA_W-1:0]   s_tdata,  // request_bytes[10:0], release_offset[20:11]
    input  wire logic                             s_tuser,  // op
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [ffba_pkg::M_TDATA_W-1:0]   m_tdata,  // payload_offset[9:0]
    output logic                                  m_tuser   // granted
);

    ffba_pkg::ffba_cmd_t cmd;
    ffba_pkg::ffba_sts_t sts;

    ffba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffba_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

### rtl/core/ffba_dpath.sv
// ============================================================================
// ffba_dpath: allocator datapath
// Tag memory with valid bits, walk pointer, request decode, split math and
// the result register.
// ============================================================================
`default_nettype none

module ffba_dpath (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic [ffba_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                             s_tuser,
    input  wire ffba_pkg::ffba_cmd_t              cmd,
    output ffba_pkg::ffba_sts_t                   sts,
    output logic      [ffba_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                                  m_tuser
);

    localparam int WA = ffba_pkg::WORD_AW;
    localparam int AW = ffba_pkg::ADDR_W;
    localparam int FW = ffba_pkg::FLAG_W;

    // Tag store
    logic [ffba_pkg::TAG_W-1:0]      tag_mem [ffba_pkg::HEAP_WORDS];
    logic [ffba_pkg::HEAP_WORDS-1:0] tag_vld_reg;
    logic [ffba_pkg::TAG_W-1:0]      rd_data_reg;
    logic                            rd_vld_reg;
    logic [WA-1:0]                   rd_addr_reg;

    // Item state
    logic                            op_reg;
    logic [ffba_pkg::NEED_W-1:0]     need_w_reg;
    logic [ffba_pkg::REL_W-1:0]      rel_word_reg;
    logic                            rel_ok_reg;
    logic [WA-1:0]                   pos_reg;
    logic [ffba_pkg::SIZE_W-1:0]     size_reg;
    logic [ffba_pkg::OFS_W-1:0]      out_ofs_reg;
    logic                            out_grant_reg;

    logic [ffba_pkg::REQ_W-1:0]      in_req;
    logic [ffba_pkg::OFS_W-1:0]      in_rel;
    logic [ffba_pkg::REL_W-1:0]      in_rel_word;
    logic [ffba_pkg::REQ_W:0]        req_round;
    logic [ffba_pkg::TAG_W-1:0]      cur_tag;
    logic [ffba_pkg::SIZE_W-1:0]     cur_size;
    logic [AW-1:0]                   next_sum;
    logic [ffba_pkg::SIZE_W-1:0]     need_size;
    logic [ffba_pkg::SIZE_W-1:0]     rest_w;
    logic [ffba_pkg::SIZE_W-1:0]     taken_w;
    logic                            split;
    logic [AW-1:0]                   rd_addr;
    logic [AW-1:0]                   wr_addr;
    logic [ffba_pkg::TAG_W-1:0]      wr_tag;
    logic                            wr_fire;
    logic [31:0]                     alloc_ofs;

    // Decode the incoming word
    assign in_req      = s_tdata[ffba_pkg::REQ_W-1:0];
    assign in_rel      = s_tdata[ffba_pkg::REQ_W +: ffba_pkg::OFS_W];
    assign in_rel_word = in_rel[ffba_pkg::OFS_W-1:FW] - ffba_pkg::REL_W'(1);
    assign req_round   = {1'b0, in_req} + (ffba_pkg::REQ_W + 1)'(7);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg       <= s_tuser;
            need_w_reg   <= ffba_pkg::NEED_W'(req_round[ffba_pkg::REQ_W:FW])
                            + ffba_pkg::NEED_W'(ffba_pkg::TAG_WORDS);
            rel_word_reg <= in_rel_word;
            rel_ok_reg   <= (in_rel[ffba_pkg::OFS_W-1:FW] != '0)
                            && (in_rel[FW-1:0] == '0)
                            && (AW'(in_rel_word) < AW'(ffba_pkg::HEAP_WORDS));
        end
    end

    // Current tag: an entry never written reads as its reset value
    always_comb begin
        if (rd_vld_reg) begin
            cur_tag = rd_data_reg;
        end else if (rd_addr_reg == '0 || rd_addr_reg == WA'(ffba_pkg::HEAP_WORDS - 1)) begin
            cur_tag = ffba_pkg::TAG_W'(ffba_pkg::HEAP_BYTES);
        end else begin
            cur_tag = '0;
        end
    end

    assign cur_size  = cur_tag[ffba_pkg::TAG_W-1:FW];
    assign next_sum  = AW'(pos_reg) + AW'(cur_size);
    assign need_size = need_w_reg[ffba_pkg::SIZE_W-1:0];
    assign rest_w    = size_reg - need_size;
    assign split     = (ffba_pkg::CMP_W'(size_reg) - ffba_pkg::CMP_W'(need_w_reg))
                       > ffba_pkg::CMP_W'(ffba_pkg::TAG_WORDS);
    assign taken_w   = split ? need_size : size_reg;

    assign sts.op_release = (op_reg == ffba_pkg::OP_RELEASE);
    assign sts.rel_ok     = rel_ok_reg;
    assign sts.fit        = (cur_tag[FW-1:0] == ffba_pkg::CLEAR_FLAGS)
                            && (ffba_pkg::CMP_W'(cur_size) >= ffba_pkg::CMP_W'(need_w_reg));
    assign sts.chain_end  = (cur_size == '0) || (next_sum >= AW'(ffba_pkg::HEAP_WORDS));
    assign sts.split      = split;

    // Walk pointer
    always_ff @(posedge aclk) begin
        if (cmd.rd_en && cmd.rd_src == ffba_pkg::RD_ZERO) begin
            pos_reg <= '0;
        end else if (cmd.rd_en && cmd.rd_src == ffba_pkg::RD_NEXT) begin
            pos_reg <= next_sum[WA-1:0];
        end
        if (cmd.latch_size) begin
            size_reg <= cur_size;
        end
    end

    // Select read address
    always_comb begin
        unique case (cmd.rd_src)
            ffba_pkg::RD_ZERO: rd_addr = '0;
            ffba_pkg::RD_NEXT: rd_addr = next_sum;
            ffba_pkg::RD_REL:  rd_addr = AW'(rel_word_reg);
            default:           rd_addr = '0;
        endcase
    end

    // Select write address and tag
    always_comb begin
        unique case (cmd.wr_src)
            ffba_pkg::WR_HDR: begin
                wr_addr = AW'(pos_reg);
                wr_tag  = {taken_w, ffba_pkg::TAKEN_FLAGS};
            end
            ffba_pkg::WR_FTR: begin
                wr_addr = AW'(pos_reg) + AW'(taken_w) - AW'(1);
                wr_tag  = {taken_w, ffba_pkg::TAKEN_FLAGS};
            end
            ffba_pkg::WR_RHDR: begin
                wr_addr = AW'(pos_reg) + AW'(need_size);
                wr_tag  = {rest_w, ffba_pkg::CLEAR_FLAGS};
            end
            ffba_pkg::WR_RFTR: begin
                wr_addr = AW'(pos_reg) + AW'(size_reg) - AW'(1);
                wr_tag  = {rest_w, ffba_pkg::CLEAR_FLAGS};
            end
            ffba_pkg::WR_REL: begin
                wr_addr = AW'(rel_word_reg);
                wr_tag  = {cur_size, ffba_pkg::CLEAR_FLAGS};
            end
            default: begin
                wr_addr = '0;
                wr_tag  = '0;
            end
        endcase
    end

    assign wr_fire = cmd.wr_en && (wr_addr < AW'(ffba_pkg::HEAP_WORDS));

    // Tag memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (wr_fire) begin
            tag_mem[wr_addr[WA-1:0]] <= wr_tag;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= tag_mem[rd_addr[WA-1:0]];
            rd_vld_reg  <= tag_vld_reg[rd_addr[WA-1:0]];
            rd_addr_reg <= rd_addr[WA-1:0];
        end
    end

    // Mark entries written since reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_vld_reg <= '0;
        end else if (wr_fire) begin
            tag_vld_reg[wr_addr[WA-1:0]] <= 1'b1;
        end
    end

    // Result register
    assign alloc_ofs = (32'(pos_reg) + 32'd1) << FW;

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            case (cmd.res_kind)
                ffba_pkg::RES_ALLOC: begin
                    out_ofs_reg   <= alloc_ofs[ffba_pkg::OFS_W-1:0];
                    out_grant_reg <= 1'b1;
                end
                ffba_pkg::RES_REL: begin
                    out_ofs_reg   <= '0;
                    out_grant_reg <= 1'b1;
                end
                default: begin
                    out_ofs_reg   <= '0;
                    out_grant_reg <= 1'b0;
                end
            endcase
        end
    end

    assign m_tdata = ffba_pkg::M_TDATA_W'(out_ofs_reg);
    assign m_tuser = out_grant_reg;

    // A walk step never reads past the heap
    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.rd_en && cmd.rd_src == ffba_pkg::RD_NEXT)
        |-> (next_sum < AW'(ffba_pkg::HEAP_WORDS)))
        else $error("walk read beyond heap");

    // Footers of a granted block always land inside the heap
    a_footer_in_heap: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr_en && (cmd.wr_src == ffba_pkg::WR_FTR || cmd.wr_src == ffba_pkg::WR_RFTR))
        |-> wr_fire)
        else $error("footer write outside heap");

    // A granted block was found large enough: its latched size covers the need
    a_fit_before_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.latch_size |=> (ffba_pkg::CMP_W'(size_reg) >= ffba_pkg::CMP_W'(need_w_reg)))
        else $error("latched block smaller than request");

endmodule

`default_nettype wire

### rtl/core/ffba_ctrl.sv
// ============================================================================
// ffba_ctrl: allocator controller
// Sequences decode, header walk, tag writes and result hand-off, and owns
// the input ready and output valid.
// ============================================================================
`default_nettype none

module ffba_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire ffba_pkg::ffba_sts_t  sts,
    output ffba_pkg::ffba_cmd_t       cmd
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_DECODE  = 4'd1;
    localparam logic [3:0] ST_REL_WR  = 4'd2;
    localparam logic [3:0] ST_WALK    = 4'd3;
    localparam logic [3:0] ST_WR_HDR  = 4'd4;
    localparam logic [3:0] ST_WR_FTR  = 4'd5;
    localparam logic [3:0] ST_WR_RHDR = 4'd6;
    localparam logic [3:0] ST_WR_RFTR = 4'd7;
    localparam logic [3:0] ST_OUT     = 4'd8;

    logic [3:0]          state_reg, state_next;
    ffba_pkg::res_kind_t kind_reg, kind_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic                out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // Next state and commands
    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        cmd            = '0;
        cmd.rd_src     = ffba_pkg::RD_ZERO;
        cmd.wr_src     = ffba_pkg::WR_HDR;
        cmd.res_kind   = kind_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (sts.op_release) begin
                    if (sts.rel_ok) begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_src = ffba_pkg::RD_REL;
                        state_next = ST_REL_WR;
                    end else begin
                        kind_next  = ffba_pkg::RES_FAIL;
                        state_next = ST_OUT;
                    end
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_src = ffba_pkg::RD_ZERO;
                    state_next = ST_WALK;
                end
            end
            ST_REL_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = ffba_pkg::WR_REL;
                kind_next  = ffba_pkg::RES_REL;
                state_next = ST_OUT;
            end
            ST_WALK: begin
                if (sts.fit) begin
                    cmd.latch_size = 1'b1;
                    state_next     = ST_WR_HDR;
                end else if (sts.chain_end) begin
                    kind_next  = ffba_pkg::RES_FAIL;
                    state_next = ST_OUT;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_src = ffba_pkg::RD_NEXT;
                end
            end
            ST_WR_HDR: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = ffba_pkg::WR_HDR;
                state_next = ST_WR_FTR;
            end
            ST_WR_FTR: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = ffba_pkg::WR_FTR;
                if (sts.split) begin
                    state_next = ST_WR_RHDR;
                end else begin
                    kind_next  = ffba_pkg::RES_ALLOC;
                    state_next = ST_OUT;
                end
            end
            ST_WR_RHDR: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = ffba_pkg::WR_RHDR;
                state_next = ST_WR_RFTR;
            end
            ST_WR_RFTR: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = ffba_pkg::WR_RFTR;
                kind_next  = ffba_pkg::RES_ALLOC;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // Hold the result until the output register frees up
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on load, drop when the word is taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            kind_reg     <= ffba_pkg::RES_FAIL;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            kind_reg     <= kind_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // An accepted word always goes to decode next
    a_accept_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_DECODE))
        else $error("accepted word not decoded");

    // A result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> out_free)
        else $error("result register overwritten");

    // A waiting result stays offered until it is taken
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result withdrawn before accept");

endmodule

`default_nettype wire

### dv/tb_first_fit_block_allocator_top.sv
// ============================================================================
// tb_first_fit_block_allocator_top: stream test of the first-fit allocator
// Drives allocate and release words into the block, predicts each result
// word from a private copy of the boundary-tag heap, and checks every result
// in order. Runs a directed opening, then random traffic under several
// sender/receiver idling mixes, including one long receiver hold-off.
// ============================================================================

// One expected result word
typedef struct packed {
    logic [ffba_pkg::OFS_W-1:0] offset;
    logic                       granted;
} grant_t;

// Heap tag predictor and in-order result checker
class heap_scoreboard;
    logic [ffba_pkg::TAG_W-1:0] tags [ffba_pkg::HEAP_WORDS];
    grant_t pending_q[$];
    int     live_offsets[$];
    int     mismatches;
    int     words_in;
    int     results_seen;
    int     grants;
    int     no_fits;
    int     splits;
    int     releases;
    int     bad_releases;

    function new();
        foreach (tags[i]) tags[i] = '0;
        // Heap starts as one free block: header and footer hold its size
        tags[0]                       = ffba_pkg::TAG_W'(ffba_pkg::HEAP_BYTES);
        tags[ffba_pkg::HEAP_WORDS-1]  = ffba_pkg::TAG_W'(ffba_pkg::HEAP_BYTES);
        mismatches   = 0;
        words_in     = 0;
        results_seen = 0;
        grants       = 0;
        no_fits      = 0;
        splits       = 0;
        releases     = 0;
        bad_releases = 0;
    endfunction

    function int tag_at(int pos);
        if (pos / 8 < ffba_pkg::HEAP_WORDS) return int'(tags[pos / 8]);
        return 0;
    endfunction

    function void put_tag(int pos, int value);
        if (pos / 8 < ffba_pkg::HEAP_WORDS) tags[pos / 8] = value[ffba_pkg::TAG_W-1:0];
    endfunction

    // Predict the result of one accepted word and queue it
    function void note_word(logic op, int req, int rel);
        grant_t exp;
        int     need;
        int     pos;
        int     size;
        int     tag;
        int     rest;
        bit     found;
        bit     done;
        words_in++;
        exp.offset  = '0;
        exp.granted = 1'b0;
        if (op == ffba_pkg::OP_RELEASE) begin
            if (rel >= 8 && (rel % 8) == 0 && rel - 8 < ffba_pkg::HEAP_BYTES) begin
                // Clear flag bits of the header only, no merge
                put_tag(rel - 8, tag_at(rel - 8) & ~int'(3'b111));
                exp.granted = 1'b1;
                releases++;
                foreach (live_offsets[i]) begin
                    if (live_offsets[i] == rel) begin
                        live_offsets.delete(i);
                        break;
                    end
                end
            end else begin
                bad_releases++;
            end
        end else begin
            need  = ((req + 7) & ~7) + 16;
            pos   = 0;
            size  = 0;
            found = 0;
            done  = 0;
            // First-fit walk over the headers
            while (!done && pos < ffba_pkg::HEAP_BYTES) begin
                tag  = tag_at(pos);
                size = tag & ~int'(3'b111);
                if ((tag & 7) == 0 && size >= need) begin
                    found = 1;
                    done  = 1;
                end else if (size < 8) begin
                    done = 1;
                end else begin
                    pos += size;
                end
            end
            if (found) begin
                if (size - need > 16) begin
                    rest = size - need;
                    put_tag(pos + need, rest);
                    put_tag(pos + size - 8, rest);
                    put_tag(pos, need | int'(ffba_pkg::TAKEN_FLAGS));
                    put_tag(pos + need - 8, need | int'(ffba_pkg::TAKEN_FLAGS));
                    splits++;
                end else begin
                    put_tag(pos, size | int'(ffba_pkg::TAKEN_FLAGS));
                    put_tag(pos + size - 8, size | int'(ffba_pkg::TAKEN_FLAGS));
                end
                exp.offset  = ffba_pkg::OFS_W'((pos + 8) % 1024);
                exp.granted = 1'b1;
                live_offsets.push_back(pos + 8);
                grants++;
            end else begin
                no_fits++;
            end
        end
        pending_q.push_back(exp);
    endfunction

    task report_mismatch(string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Compare one accepted result word with the oldest expectation
    task check_word(logic [ffba_pkg::OFS_W-1:0] offset, logic granted);
        grant_t exp;
        results_seen++;
        if (pending_q.size() == 0) begin
            report_mismatch($sformatf("result offset=%0d granted=%0b with nothing outstanding",
                                      offset, granted));
        end else begin
            exp = pending_q.pop_front();
            if (offset !== exp.offset)
                report_mismatch($sformatf("result %0d payload_offset got %0d want %0d",
                                          results_seen, offset, exp.offset));
            if (granted !== exp.granted)
                report_mismatch($sformatf("result %0d granted got %0b want %0b",
                                          results_seen, granted, exp.granted));
        end
    endtask
endclass

module tb_first_fit_block_allocator_top;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASE_WORDS  = 100;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [ffba_pkg::S_TDATA_W-1:0]  s_tdata;  // request_bytes[10:0], release_offset[20:11]
    logic                            s_tuser;  // op
    logic                            m_tvalid;
    logic                            m_tready;
    logic [ffba_pkg::M_TDATA_W-1:0]  m_tdata;  // payload_offset[9:0]
    logic                            m_tuser;  // granted

    int             src_idle_pct;
    int             sink_idle_pct;
    logic           hold_go;
    logic           sink_hold;
    int             cycle_count;
    heap_scoreboard sb;

    first_fit_block_allocator_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Bound the run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: random stalls, forced low during a hold-off
    always @(negedge aclk) begin
        m_tready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
    end

    // Long receiver hold-off, counted here once the sender asks for it
    initial begin
        sink_hold = 1'b0;
        wait (hold_go === 1'b1);
        sink_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        sink_hold = 1'b0;
    end

    // Note accepted input words
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_word(s_tuser, int'(s_tdata[ffba_pkg::REQ_W-1:0]),
                         int'(s_tdata[ffba_pkg::REQ_W+ffba_pkg::OFS_W-1:ffba_pkg::REQ_W]));
    end

    // Check accepted result words
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_word(m_tdata[ffba_pkg::OFS_W-1:0], m_tuser);
    end

    // Offer one word; called and returns at a falling edge
    task automatic send_word(logic op, int req, int rel);
        logic [ffba_pkg::S_TDATA_W-1:0] word;
        word                                   = '0;
        word[ffba_pkg::REQ_W-1:0]              = req[ffba_pkg::REQ_W-1:0];
        word[ffba_pkg::REQ_W+ffba_pkg::OFS_W-1:ffba_pkg::REQ_W] = rel[ffba_pkg::OFS_W-1:0];
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic alloc_word(int req);
        send_word(ffba_pkg::OP_ALLOC, req, $urandom_range(1023));
    endtask

    task automatic release_word(int ofs);
        send_word(ffba_pkg::OP_RELEASE, $urandom_range(1024), ofs);
    endtask

    // Mostly small requests so splits and reuse keep happening
    function automatic int random_len();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(64);
        if (r < 90) return $urandom_range(256, 65);
        return $urandom_range(1024, 257);
    endfunction

    // Random traffic: allocates, releases of live blocks, some junk releases
    task automatic random_words(int count);
        int pick;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 10)
                release_word($urandom_range(1023));
            else if (pick < 45 && sb.live_offsets.size() > 0)
                release_word(sb.live_offsets[$urandom_range(sb.live_offsets.size() - 1)]);
            else
                alloc_word(random_len());
        end
    endtask

    initial begin
        sb            = new();
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tuser       = ffba_pkg::OP_ALLOC;
        s_tdata       = '0;
        hold_go       = 1'b0;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: split, no fit, whole-block take, bad and stray releases
        alloc_word(0);        // split at heap start
        alloc_word(1);        // rounds up to 8
        alloc_word(1024);     // larger than the heap
        alloc_word(1023);
        alloc_word(1000);     // no block large enough
        alloc_word(960);      // leftover of 8 stays in the block
        alloc_word(0);        // heap full
        release_word(8);
        alloc_word(0);        // reuse exactly, no leftover
        release_word(0);      // below the first payload
        release_word(13);     // misaligned
        release_word(1023);   // misaligned, all bits set
        release_word(1016);   // aligned but never granted
        release_word(48);
        alloc_word(7);        // split the released block
        release_word(24);
        alloc_word(8);        // fits the 24-byte hole exactly
        release_word(8);
        release_word(8);      // second release of the same block

        // Phase: no idling, with a long receiver hold-off to back up the input
        hold_go = 1'b1;
        random_words(PHASE_WORDS);

        // Phase: sender idles
        src_idle_pct  = 45;
        sink_idle_pct = 0;
        random_words(PHASE_WORDS);

        // Phase: receiver stalls
        src_idle_pct  = 0;
        sink_idle_pct = 45;
        random_words(PHASE_WORDS);

        // Phase: both idle
        src_idle_pct  = 28;
        sink_idle_pct = 28;
        random_words(PHASE_WORDS);

        // Drain
        s_tvalid      <= 1'b0;
        sink_idle_pct = 0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.pending_q.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending_q.size()));

        $display("Covered %0d words: %0d grants (%0d split), %0d no-fit allocates,",
                 sb.words_in, sb.grants, sb.splits, sb.no_fits);
        $display("  %0d releases done, %0d rejected; %0d mismatches in %0d cycles",
                 sb.releases, sb.bad_releases, sb.mismatches, cycle_count);
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
